// ===== src/glh_pkg.sv =====
// glh_pkg: shared types, widths, register indexes and the arctangent table
// for the ground plane line heading pipeline. No dependencies.

package glh_pkg;

    localparam int OFFS_W   = 13;   // roi offset registers, signed
    localparam int REG_W    = 16;   // widest configuration register
    localparam int OUT_W    = 16;   // heading output
    localparam int IDX_W    = 2;    // configuration register index
    localparam int NORM_BIT = 40;   // cordic operands are normalized to this bit
    localparam int MAG_W    = NORM_BIT + 1;
    localparam int XY_W     = MAG_W + 3;   // cordic x/y with gain headroom and sign
    localparam int Z_W      = 32;          // cordic angle accumulator, Q30
    localparam int RQ_W     = 33;          // signed heading in Q30
    localparam int TABLE_LEN = 24;
    localparam int Q_FRAC   = 30;

    localparam logic [IDX_W-1:0] REG_ROI_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_ROI_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_CAM_H = 2'd2;
    localparam logic [IDX_W-1:0] REG_FOCAL = 2'd3;

    localparam logic signed [RQ_W-1:0] PI_Q30      = 33'sd3373259426;
    localparam logic signed [RQ_W-1:0] HALF_PI_Q30 = 33'sd1686629713;

    typedef struct packed {
        logic signed [OFFS_W-1:0] roi_x;
        logic signed [OFFS_W-1:0] roi_y;
        logic [REG_W-1:0]         focal;
        logic                     cam_zero;
    } cfg_t;

    typedef struct packed {
        logic degen;
        logic dx_zero;
        logic dy_zero;
        logic pos;
    } side_t;

    // atan(2^-i) in Q30, truncated
    function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = 32'sd843314856;
            1:  v = 32'sd497837829;
            2:  v = 32'sd263043836;
            3:  v = 32'sd133525158;
            4:  v = 32'sd67021686;
            5:  v = 32'sd33543515;
            6:  v = 32'sd16775850;
            7:  v = 32'sd8388437;
            8:  v = 32'sd4194282;
            9:  v = 32'sd2097149;
            10: v = 32'sd1048575;
            11: v = 32'sd524287;
            12: v = 32'sd262143;
            13: v = 32'sd131071;
            14: v = 32'sd65535;
            15: v = 32'sd32767;
            16: v = 32'sd16383;
            17: v = 32'sd8191;
            18: v = 32'sd4095;
            19: v = 32'sd2047;
            20: v = 32'sd1023;
            21: v = 32'sd511;
            22: v = 32'sd255;
            23: v = 32'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/glh_front.sv =====
// glh_front: three pipeline stages that shift the endpoints by the roi offset,
// form the cross products and take their magnitudes. Depends on glh_pkg.

module glh_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [COORD_BITS-1:0]       start_x,
    input  logic [COORD_BITS-1:0]       start_y,
    input  logic [COORD_BITS-1:0]       end_x,
    input  logic [COORD_BITS-1:0]       end_y,
    input  glh_pkg::cfg_t               cfg,
    output logic                        out_valid,
    output logic [glh_pkg::MAG_W-1:0]   adx,
    output logic [glh_pkg::MAG_W-1:0]   ady,
    output glh_pkg::side_t              side
);

    localparam int SW   = ((COORD_BITS + 1 > glh_pkg::OFFS_W) ?
                           COORD_BITS + 1 : glh_pkg::OFFS_W) + 1;
    localparam int DW   = SW + 1;
    localparam int P_W  = 2 * SW;
    localparam int DX_W = P_W + 1;
    localparam int DY_W = DW + glh_pkg::REG_W + 1;

    logic v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;

    logic signed [SW-1:0]   x0_reg, x0_next, y0_reg, y0_next;
    logic signed [SW-1:0]   x1_reg, x1_next, y1_reg, y1_next;
    logic                   dg1_reg, dg1_next;
    logic signed [P_W-1:0]  p0_reg, p0_next, p1_reg, p1_next;
    logic signed [DY_W-1:0] dy_reg, dy_next;
    logic                   dg2_reg, dg2_next;
    logic [glh_pkg::MAG_W-1:0] adx_reg, adx_next, ady_reg, ady_next;
    glh_pkg::side_t         side_reg, side_next;

    logic signed [DW-1:0]   dyd;
    logic signed [DX_W-1:0] dx;
    logic [DX_W-1:0]        adx_abs;
    logic [DY_W-1:0]        ady_abs;
    logic                   dx_pos, dy_pos;

    assign v1_next = in_valid;
    assign v2_next = v1_reg;
    assign v3_next = v2_reg;

    // stage 1: shift into the image-centre frame
    always_comb
    begin
        x0_next  = SW'($signed({1'b0, start_x})) - SW'(cfg.roi_x);
        y0_next  = SW'($signed({1'b0, start_y})) - SW'(cfg.roi_y);
        x1_next  = SW'($signed({1'b0, end_x})) - SW'(cfg.roi_x);
        y1_next  = SW'($signed({1'b0, end_y})) - SW'(cfg.roi_y);
        dg1_next = (y0_next == '0) || (y1_next == '0) || cfg.cam_zero;
    end

    // stage 2: products, camera height cancels out
    always_comb
    begin
        dyd      = DW'(y0_reg) - DW'(y1_reg);
        p0_next  = P_W'(x1_reg) * P_W'(y0_reg);
        p1_next  = P_W'(x0_reg) * P_W'(y1_reg);
        dy_next  = DY_W'(dyd) * DY_W'($signed({1'b0, cfg.focal}));
        dg2_next = dg1_reg;
    end

    // stage 3: magnitudes and quadrant flags
    always_comb
    begin
        dx       = DX_W'(p0_reg) - DX_W'(p1_reg);
        adx_abs  = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
        ady_abs  = dy_reg[DY_W-1] ? DY_W'(-dy_reg) : DY_W'(dy_reg);
        adx_next = glh_pkg::MAG_W'(adx_abs);
        ady_next = glh_pkg::MAG_W'(ady_abs);
        dx_pos   = !dx[DX_W-1] && (dx != '0);
        dy_pos   = !dy_reg[DY_W-1] && (dy_reg != '0);
        side_next.degen   = dg2_reg;
        side_next.dx_zero = (dx == '0);
        side_next.dy_zero = (dy_reg == '0);
        side_next.pos     = (dy_reg != '0) && (dy_pos == dx_pos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg   <= x0_next;
        y0_reg   <= y0_next;
        x1_reg   <= x1_next;
        y1_reg   <= y1_next;
        dg1_reg  <= dg1_next;
        p0_reg   <= p0_next;
        p1_reg   <= p1_next;
        dy_reg   <= dy_next;
        dg2_reg  <= dg2_next;
        adx_reg  <= adx_next;
        ady_reg  <= ady_next;
        side_reg <= side_next;
    end

    assign out_valid = v3_reg;
    assign adx       = adx_reg;
    assign ady       = ady_reg;
    assign side      = side_reg;

endmodule

// ===== src/glh_norm.sv =====
// glh_norm: pipelined normalizer that shifts both magnitudes left until the
// larger one has its top bit set, two shift steps per stage. Depends on glh_pkg.

module glh_norm (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [glh_pkg::MAG_W-1:0]   in_a,
    input  logic [glh_pkg::MAG_W-1:0]   in_b,
    input  glh_pkg::side_t              in_side,
    output logic                        out_valid,
    output logic [glh_pkg::MAG_W-1:0]   out_a,
    output logic [glh_pkg::MAG_W-1:0]   out_b,
    output glh_pkg::side_t              out_side
);

    localparam int NORM_STAGES = 3;   // shifts 32,16 | 8,4 | 2,1

    logic [NORM_STAGES-1:0]      v_reg, v_next;
    logic [glh_pkg::MAG_W-1:0]   a_reg [NORM_STAGES];
    logic [glh_pkg::MAG_W-1:0]   a_next [NORM_STAGES];
    logic [glh_pkg::MAG_W-1:0]   b_reg [NORM_STAGES];
    logic [glh_pkg::MAG_W-1:0]   b_next [NORM_STAGES];
    glh_pkg::side_t              side_reg [NORM_STAGES];
    glh_pkg::side_t              side_next [NORM_STAGES];

    for (genvar s = 0; s < NORM_STAGES; s++)
    begin : g_stage
        localparam int K_HI = 1 << (2 * (NORM_STAGES - 1 - s) + 1);
        localparam int K_LO = K_HI / 2;

        logic [glh_pkg::MAG_W-1:0] a_in, b_in;
        glh_pkg::side_t            side_in;
        logic                      v_in;

        if (s == 0)
        begin : g_first
            assign a_in    = in_a;
            assign b_in    = in_b;
            assign side_in = in_side;
            assign v_in    = in_valid;
        end
        else
        begin : g_rest
            assign a_in    = a_reg[s-1];
            assign b_in    = b_reg[s-1];
            assign side_in = side_reg[s-1];
            assign v_in    = v_reg[s-1];
        end

        always_comb
        begin : shift
            logic [glh_pkg::MAG_W-1:0] a, b, m;
            a = a_in;
            b = b_in;
            m = a_in | b_in;
            if (m[glh_pkg::MAG_W-1 -: K_HI] == '0)
            begin
                a = a << K_HI;
                b = b << K_HI;
                m = m << K_HI;
            end
            if (m[glh_pkg::MAG_W-1 -: K_LO] == '0)
            begin
                a = a << K_LO;
                b = b << K_LO;
            end
            a_next[s]    = a;
            b_next[s]    = b;
            side_next[s] = side_in;
            v_next[s]    = v_in;
        end

        always_ff @(posedge clk)
        begin
            a_reg[s]    <= a_next[s];
            b_reg[s]    <= b_next[s];
            side_reg[s] <= side_next[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign out_valid = v_reg[NORM_STAGES-1];
    assign out_a     = a_reg[NORM_STAGES-1];
    assign out_b     = b_reg[NORM_STAGES-1];
    assign out_side  = side_reg[NORM_STAGES-1];

endmodule

// ===== src/glh_cordic.sv =====
// glh_cordic: unrolled vectoring cordic, one micro-rotation per register stage,
// accumulating atan(b/a) in Q30. Depends on glh_pkg.

module glh_cordic #(
    parameter int STEPS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [glh_pkg::MAG_W-1:0]         in_a,
    input  logic [glh_pkg::MAG_W-1:0]         in_b,
    input  glh_pkg::side_t                    in_side,
    output logic                              out_valid,
    output logic signed [glh_pkg::Z_W-1:0]    out_z,
    output glh_pkg::side_t                    out_side
);

    localparam int XW = glh_pkg::XY_W;
    localparam int ZW = glh_pkg::Z_W;

    logic [STEPS-1:0]       v_reg, v_next;
    logic signed [XW-1:0]   x_reg [STEPS];
    logic signed [XW-1:0]   x_next [STEPS];
    logic signed [XW-1:0]   y_reg [STEPS];
    logic signed [XW-1:0]   y_next [STEPS];
    logic signed [ZW-1:0]   z_reg [STEPS];
    logic signed [ZW-1:0]   z_next [STEPS];
    glh_pkg::side_t         side_reg [STEPS];
    glh_pkg::side_t         side_next [STEPS];

    for (genvar s = 0; s < STEPS; s++)
    begin : g_step
        logic signed [XW-1:0] x_in, y_in;
        logic signed [ZW-1:0] z_in;
        glh_pkg::side_t       side_in;
        logic                 v_in;

        if (s == 0)
        begin : g_first
            assign x_in    = XW'($signed({1'b0, in_a}));
            assign y_in    = XW'($signed({1'b0, in_b}));
            assign z_in    = '0;
            assign side_in = in_side;
            assign v_in    = in_valid;
        end
        else
        begin : g_rest
            assign x_in    = x_reg[s-1];
            assign y_in    = y_reg[s-1];
            assign z_in    = z_reg[s-1];
            assign side_in = side_reg[s-1];
            assign v_in    = v_reg[s-1];
        end

        // rotate toward the x axis; y of zero rotates the negative way
        always_comb
        begin
            if (y_in > 0)
            begin
                x_next[s] = x_in + (y_in >>> s);
                y_next[s] = y_in - (x_in >>> s);
                z_next[s] = z_in + glh_pkg::atan_q30(s);
            end
            else
            begin
                x_next[s] = x_in - (y_in >>> s);
                y_next[s] = y_in + (x_in >>> s);
                z_next[s] = z_in - glh_pkg::atan_q30(s);
            end
            side_next[s] = side_in;
            v_next[s]    = v_in;
        end

        always_ff @(posedge clk)
        begin
            x_reg[s]    <= x_next[s];
            y_reg[s]    <= y_next[s];
            z_reg[s]    <= z_next[s];
            side_reg[s] <= side_next[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign out_valid = v_reg[STEPS-1];
    assign out_z     = z_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

// ===== src/ground_plane_line_heading.sv =====
// ground_plane_line_heading: top level with the configuration registers and the
// final rounding stages. Depends on glh_pkg, glh_front, glh_norm and glh_cordic.

// The block takes one line segment per clock: a transaction is accepted whenever
// start is high, and busy stays low, so segments may arrive back to back without
// gaps. Each segment yields exactly one result after passing through three front
// stages for offset, products and magnitudes, three normalizer stages, one stage
// per cordic micro-rotation, and two output stages, one folding the angle into the
// heading quadrant and one for rounding and saturation. The result is shown on
// heading_angle and degenerate for the single cycle in which done is high and
// must be captured then, as the receiver cannot stall the pipeline.
// Configuration registers are written through cfg_write, cfg_index and cfg_data
// and should change only while no segment is in flight.

module ground_plane_line_heading #(
    parameter int COORD_BITS      = 12,
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [COORD_BITS-1:0]             start_x,
    input  logic [COORD_BITS-1:0]             start_y,
    input  logic [COORD_BITS-1:0]             end_x,
    input  logic [COORD_BITS-1:0]             end_y,
    input  logic                              cfg_write,
    input  logic [glh_pkg::IDX_W-1:0]         cfg_index,
    input  logic [glh_pkg::REG_W-1:0]         cfg_data,
    output logic                              done,
    output logic signed [glh_pkg::OUT_W-1:0]  heading_angle,
    output logic                              degenerate
);

    localparam int STEPS   = (CORDIC_STEPS > glh_pkg::TABLE_LEN) ?
                             glh_pkg::TABLE_LEN : CORDIC_STEPS;
    localparam int LATENCY = STEPS + 8;
    localparam int RQ_W    = glh_pkg::RQ_W;
    localparam int SH      = glh_pkg::Q_FRAC - ANGLE_FRAC_BITS;
    localparam int ROUND_HALF = 1 << (SH - 1);
    localparam logic signed [RQ_W:0] SAT_HI = (RQ_W+1)'((1 << (glh_pkg::OUT_W - 1)) - 1);
    localparam logic signed [RQ_W:0] SAT_LO = -(RQ_W+1)'(1 << (glh_pkg::OUT_W - 1));

    logic signed [glh_pkg::OFFS_W-1:0] roi_x_reg, roi_x_next, roi_y_reg, roi_y_next;
    logic [glh_pkg::REG_W-1:0]         cam_h_reg, cam_h_next, focal_reg, focal_next;
    glh_pkg::cfg_t                     cfg;

    logic                        accept;
    logic                        fr_valid, nm_valid, cd_valid;
    logic [glh_pkg::MAG_W-1:0]   fr_adx, fr_ady, nm_a, nm_b;
    glh_pkg::side_t              fr_side, nm_side, cd_side;
    logic signed [glh_pkg::Z_W-1:0] cd_z;

    logic                        rv_reg, rv_next, done_reg, done_next;
    logic signed [RQ_W-1:0]      rq_reg, rq_next;
    logic                        rdg_reg, rdg_next;
    logic signed [glh_pkg::OUT_W-1:0] heading_reg, heading_next;
    logic                        degen_reg, degen_next;

    logic signed [RQ_W-1:0]      z_ext, phi;
    logic signed [RQ_W:0]        rnd, r;

    // the pipeline takes a transaction every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        roi_x_next = roi_x_reg;
        roi_y_next = roi_y_reg;
        cam_h_next = cam_h_reg;
        focal_next = focal_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                glh_pkg::REG_ROI_X: roi_x_next = cfg_data[glh_pkg::OFFS_W-1:0];
                glh_pkg::REG_ROI_Y: roi_y_next = cfg_data[glh_pkg::OFFS_W-1:0];
                glh_pkg::REG_CAM_H: cam_h_next = cfg_data;
                glh_pkg::REG_FOCAL: focal_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roi_x_reg <= '0;
            roi_y_reg <= '0;
            cam_h_reg <= glh_pkg::REG_W'(1);
            focal_reg <= glh_pkg::REG_W'(1024);
        end
        else
        begin
            roi_x_reg <= roi_x_next;
            roi_y_reg <= roi_y_next;
            cam_h_reg <= cam_h_next;
            focal_reg <= focal_next;
        end
    end

    always_comb
    begin
        cfg.roi_x    = roi_x_reg;
        cfg.roi_y    = roi_y_reg;
        cfg.focal    = focal_reg;
        cfg.cam_zero = (cam_h_reg == '0);
    end

    glh_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .cfg       (cfg),
        .out_valid (fr_valid),
        .adx       (fr_adx),
        .ady       (fr_ady),
        .side      (fr_side)
    );

    glh_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_a      (fr_adx),
        .in_b      (fr_ady),
        .in_side   (fr_side),
        .out_valid (nm_valid),
        .out_a     (nm_a),
        .out_b     (nm_b),
        .out_side  (nm_side)
    );

    glh_cordic #(
        .STEPS (STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (nm_valid),
        .in_a      (nm_a),
        .in_b      (nm_b),
        .in_side   (nm_side),
        .out_valid (cd_valid),
        .out_z     (cd_z),
        .out_side  (cd_side)
    );

    // clamp the cordic angle and fold it into the heading quadrant
    always_comb
    begin
        z_ext = RQ_W'(cd_z);
        if (z_ext < 0)
            phi = '0;
        else if (z_ext > glh_pkg::HALF_PI_Q30)
            phi = glh_pkg::HALF_PI_Q30;
        else
            phi = z_ext;
        if (cd_side.dy_zero)
            phi = '0;

        if (cd_side.dx_zero)
            rq_next = -glh_pkg::HALF_PI_Q30;
        else if (cd_side.pos)
            rq_next = -phi;
        else
            rq_next = phi - glh_pkg::PI_Q30;
        rdg_next = cd_side.degen;
        rv_next  = cd_valid;
    end

    // round half up to the output fraction and saturate; a degenerate result gives zero
    always_comb
    begin
        rnd = (RQ_W+1)'(rq_reg) + (RQ_W+1)'(ROUND_HALF);
        r   = rnd >>> SH;
        if (rdg_reg)
            heading_next = '0;
        else if (r > SAT_HI)
            heading_next = SAT_HI[glh_pkg::OUT_W-1:0];
        else if (r < SAT_LO)
            heading_next = SAT_LO[glh_pkg::OUT_W-1:0];
        else
            heading_next = r[glh_pkg::OUT_W-1:0];
        degen_next = rdg_reg;
        done_next  = rv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rv_reg   <= rv_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rq_reg      <= rq_next;
        rdg_reg     <= rdg_next;
        heading_reg <= heading_next;
        degen_reg   <= degen_next;
    end

    assign done          = done_reg;
    assign heading_angle = heading_reg;
    assign degenerate    = degen_reg;

    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted transaction gave no result at the pipeline latency");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching accepted transaction");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (heading_angle == '0))
        else $error("degenerate result carries a nonzero heading");

    a_heading_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !degenerate) |-> (heading_angle <= 0))
        else $error("heading above zero");

endmodule

// ===== sim/ground_plane_line_heading_test.sv =====
// ground_plane_line_heading_test: self-checking bench for the ground plane line heading
// pipeline, with a bit-true heading predictor kept inside the bench.
// Depends on glh_pkg (widths, register indexes) and ground_plane_line_heading.

module ground_plane_line_heading_test;

    localparam int CLK_PERIOD  = 8;
    localparam int COORD_W     = 12;
    localparam int FRAC_W      = 13;
    localparam int STEPS       = 16;
    localparam int LATENCY     = STEPS + 8;
    localparam int ROUND_SH    = 30 - FRAC_W;
    localparam int NORM_POS    = 40;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 110;
    localparam int STALL_LIMIT = 2000;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;
    localparam int OFFS_MAX    = 4095;

    localparam longint PI_Q      = 64'sd3373259426;
    localparam longint HALF_PI_Q = 64'sd1686629713;

    localparam int HEADING_MINUS_HALF_PI = -12868;
    localparam int HEADING_MINUS_PI      = -25736;

    // atan(2^-i) in Q30, truncated
    localparam longint ATAN_Q30 [0:23] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };

    typedef struct packed {
        logic signed [glh_pkg::OUT_W-1:0] angle;
        logic                             degen;
    } heading_t;

    typedef enum logic {ROW_SEGMENT, ROW_REGISTER} row_kind_e;

    typedef enum int {
        SHAPE_UNIFORM,
        SHAPE_ON_HORIZON,
        SHAPE_SAME_GROUND_X,
        SHAPE_LEVEL,
        SHAPE_NEAR,
        SHAPE_CORNERS
    } seg_shape_e;

    typedef struct packed {
        row_kind_e                 kind;
        logic [glh_pkg::IDX_W-1:0] index;
        logic [glh_pkg::REG_W-1:0] value;
        logic [COORD_W-1:0]        sx;
        logic [COORD_W-1:0]        sy;
        logic [COORD_W-1:0]        ex;
        logic [COORD_W-1:0]        ey;
        logic                      known;   // heading typed in, not predicted
        heading_t                  heading;
    } plan_row_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic [COORD_W-1:0]                start_x;
    logic [COORD_W-1:0]                start_y;
    logic [COORD_W-1:0]                end_x;
    logic [COORD_W-1:0]                end_y;
    logic                              cfg_write;
    logic [glh_pkg::IDX_W-1:0]         cfg_index;
    logic [glh_pkg::REG_W-1:0]         cfg_data;
    logic                              done;
    logic signed [glh_pkg::OUT_W-1:0]  heading_angle;
    logic                              degenerate;

    // bench copy of the configuration registers
    logic signed [glh_pkg::OFFS_W-1:0] roi_x_reg;
    logic signed [glh_pkg::OFFS_W-1:0] roi_y_reg;
    logic [glh_pkg::REG_W-1:0]         cam_h_reg;
    logic [glh_pkg::REG_W-1:0]         focal_reg;

    heading_t   expected_headings [$];
    heading_t   want_heading;
    plan_row_t  directed_plan [$];

    int errors         = 0;
    int segments_sent  = 0;
    int settings_used  = 0;
    int degen_seen     = 0;
    int sideways_seen  = 0;
    int backward_seen  = 0;
    int stall_cycles   = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    ground_plane_line_heading #(
        .COORD_BITS      (COORD_W),
        .ANGLE_FRAC_BITS (FRAC_W),
        .CORDIC_STEPS    (STEPS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .heading_angle (heading_angle),
        .degenerate    (degenerate)
    );

    // atan(b/a) in Q30 by vectoring rotations, a and b positive
    function automatic longint vector_atan_q30(longint a, longint b);
        longint m;
        longint x;
        longint y;
        longint z;
        longint xn;
        int     sh;
        int     n;
        m  = a | b;
        sh = 0;
        while (m < (longint'(1) <<< NORM_POS))
        begin
            m = m <<< 1;
            sh++;
        end
        x = a <<< sh;
        y = b <<< sh;
        z = 0;
        n = (STEPS > 24) ? 24 : STEPS;
        for (int i = 0; i < n; i++)
        begin
            if (y > 0)
            begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_Q30[i];
            end
            else
            begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_Q30[i];
            end
            x = xn;
        end
        if (z < 0)
            z = 0;
        if (z > HALF_PI_Q)
            z = HALF_PI_Q;
        return z;
    endfunction

    function automatic heading_t predict_heading(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                                                 logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey);
        longint   x0;
        longint   y0;
        longint   x1;
        longint   y1;
        longint   dy;
        longint   dx;
        longint   ady;
        longint   adx;
        longint   phi;
        longint   rq;
        longint   r;
        bit       ahead;
        heading_t h;
        x0 = longint'(sx) - longint'(roi_x_reg);
        y0 = longint'(sy) - longint'(roi_y_reg);
        x1 = longint'(ex) - longint'(roi_x_reg);
        y1 = longint'(ey) - longint'(roi_y_reg);
        h  = '0;
        if (y0 == 0 || y1 == 0 || cam_h_reg == 0)
        begin
            h.degen = 1'b1;
            return h;
        end
        // camera height cancels out of the ground slope
        dy = longint'(focal_reg) * (y0 - y1);
        dx = x1 * y0 - x0 * y1;
        if (dx == 0)
            rq = -HALF_PI_Q;
        else
        begin
            ady   = (dy < 0) ? -dy : dy;
            adx   = (dx < 0) ? -dx : dx;
            phi   = (ady != 0) ? vector_atan_q30(adx, ady) : 0;
            ahead = (dy != 0) && ((dy > 0) == (dx > 0));
            rq    = ahead ? -phi : phi - PI_Q;
        end
        r = (rq + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
        if (r < -32768)
            r = -32768;
        if (r > 32767)
            r = 32767;
        h.angle = r[glh_pkg::OUT_W-1:0];
        return h;
    endfunction

    function automatic plan_row_t seg_row(int sx, int sy, int ex, int ey);
        plan_row_t row;
        row      = '0;
        row.kind = ROW_SEGMENT;
        row.sx   = COORD_W'(sx);
        row.sy   = COORD_W'(sy);
        row.ex   = COORD_W'(ex);
        row.ey   = COORD_W'(ey);
        return row;
    endfunction

    function automatic plan_row_t seg_known(int sx, int sy, int ex, int ey, int angle, bit degen);
        plan_row_t row;
        row               = seg_row(sx, sy, ex, ey);
        row.known         = 1'b1;
        row.heading.angle = glh_pkg::OUT_W'(angle);
        row.heading.degen = degen;
        return row;
    endfunction

    function automatic plan_row_t reg_row(logic [glh_pkg::IDX_W-1:0] index, int value);
        plan_row_t row;
        row       = '0;
        row.kind  = ROW_REGISTER;
        row.index = index;
        row.value = glh_pkg::REG_W'(value);
        return row;
    endfunction

    function automatic int coord_clip(int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic int corner_coord();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 1;
            2:       return COORD_MAX - 1;
            3:       return COORD_MAX;
            4:       return 1 << (COORD_W - 1);
            default: return int'($urandom_range(0, COORD_MAX));
        endcase
    endfunction

    function automatic int pick_offset();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 1) ? OFFS_MAX : -OFFS_MAX;
            1:       return 0;
            default: return int'($urandom_range(0, 2 * OFFS_MAX)) - OFFS_MAX;
        endcase
    endfunction

    task automatic write_reg(logic [glh_pkg::IDX_W-1:0] index, int value);
        @(negedge clk);
        start     <= 1'b0;
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= glh_pkg::REG_W'(value);
        @(posedge clk);
        case (index)
            glh_pkg::REG_ROI_X: roi_x_reg = glh_pkg::OFFS_W'(value);
            glh_pkg::REG_ROI_Y: roi_y_reg = glh_pkg::OFFS_W'(value);
            glh_pkg::REG_CAM_H: cam_h_reg = glh_pkg::REG_W'(value);
            glh_pkg::REG_FOCAL: focal_reg = glh_pkg::REG_W'(value);
            default:   ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // start stays high after a transaction so segments can go back to back
    task automatic drive_segment(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                                 logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey,
                                 bit known, heading_t typed);
        @(negedge clk);
        start   <= 1'b1;
        start_x <= sx;
        start_y <= sy;
        end_x   <= ex;
        end_y   <= ey;
        do
            @(posedge clk);
        while (busy);
        expected_headings.push_back(known ? typed : predict_heading(sx, sy, ex, ey));
        segments_sent++;
    endtask

    task automatic idle(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start   <= 1'b0;
            start_x <= COORD_W'($urandom);
            start_y <= COORD_W'($urandom);
            end_x   <= COORD_W'($urandom);
            end_y   <= COORD_W'($urandom);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (expected_headings.size() != 0)
            @(posedge clk);
    endtask

    task automatic pick_segment(output logic [COORD_W-1:0] sx, output logic [COORD_W-1:0] sy,
                                output logic [COORD_W-1:0] ex, output logic [COORD_W-1:0] ey);
        int         rx;
        int         ry;
        int         ax;
        int         ay;
        int         bx;
        int         by;
        int         ux;
        int         uy;
        int         k;
        int         roll;
        seg_shape_e shape;
        rx   = roi_x_reg;
        ry   = roi_y_reg;
        ax   = $urandom_range(0, COORD_MAX);
        ay   = $urandom_range(0, COORD_MAX);
        bx   = $urandom_range(0, COORD_MAX);
        by   = $urandom_range(0, COORD_MAX);
        roll = $urandom_range(0, 9);
        shape = (roll < 5) ? SHAPE_UNIFORM : seg_shape_e'(roll - 4);
        case (shape)
            SHAPE_ON_HORIZON:
            begin
                // a shifted y of zero
                if (ry >= 0 && ry <= COORD_MAX)
                begin
                    case ($urandom_range(0, 2))
                        0:       ay = ry;
                        1:       by = ry;
                        default:
                        begin
                            ay = ry;
                            by = ry;
                        end
                    endcase
                end
            end
            SHAPE_SAME_GROUND_X:
            begin
                k  = $urandom_range(2, 4);
                ux = int'($urandom_range(0, 400)) - 200;
                uy = int'($urandom_range(1, 200)) * ($urandom_range(0, 1) ? 1 : -1);
                ax = rx + ux;
                ay = ry + uy;
                bx = rx + k * ux;
                by = ry + k * uy;
                if (ax != coord_clip(ax) || ay != coord_clip(ay) ||
                    bx != coord_clip(bx) || by != coord_clip(by))
                begin
                    // endpoints coincide instead
                    ax = $urandom_range(0, COORD_MAX);
                    ay = $urandom_range(0, COORD_MAX);
                    bx = ax;
                    by = ay;
                end
            end
            SHAPE_LEVEL:
                by = ay;
            SHAPE_NEAR:
            begin
                bx = coord_clip(ax + int'($urandom_range(0, 6)) - 3);
                by = coord_clip(ay + int'($urandom_range(0, 6)) - 3);
            end
            SHAPE_CORNERS:
            begin
                ax = corner_coord();
                ay = corner_coord();
                bx = corner_coord();
                by = corner_coord();
            end
            default: ;
        endcase
        sx = COORD_W'(ax);
        sy = COORD_W'(ay);
        ex = COORD_W'(bx);
        ey = COORD_W'(by);
    endtask

    // result checker: one result per done strobe, in order
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_headings.size() == 0)
            begin
                $error("heading result with no segment outstanding: angle %0d degenerate %0b",
                       heading_angle, degenerate);
                errors++;
            end
            else
            begin
                want_heading = expected_headings.pop_front();
                if (heading_angle !== want_heading.angle)
                begin
                    $error("heading_angle mismatch: expected %0d, actual %0d",
                           want_heading.angle, heading_angle);
                    errors++;
                end
                if (degenerate !== want_heading.degen)
                begin
                    $error("degenerate mismatch: expected %0b, actual %0b",
                           want_heading.degen, degenerate);
                    errors++;
                end
                if (want_heading.degen)
                    degen_seen++;
                else if (want_heading.angle == HEADING_MINUS_HALF_PI)
                    sideways_seen++;
                else if (want_heading.angle == HEADING_MINUS_PI)
                    backward_seen++;
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $error("no transaction for %0d cycles, %0d results outstanding",
                   stall_cycles, expected_headings.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        int                 rx;
        int                 ry;
        int                 ch;
        int                 fl;
        int                 gap_every;

        rst_n     = 1'b0;
        start     = 1'b0;
        start_x   = '0;
        start_y   = '0;
        end_x     = '0;
        end_y     = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        roi_x_reg = '0;
        roi_y_reg = '0;
        cam_h_reg = glh_pkg::REG_W'(1);
        focal_reg = glh_pkg::REG_W'(1024);

        directed_plan = '{
            // reset values: offsets 0, height 1, focal 1024
            seg_known(0, 0, 0, 0, 0, 1'b1),
            seg_known(5, 7, 9, 0, 0, 1'b1),
            seg_known(10, 10, 20, 20, HEADING_MINUS_HALF_PI, 1'b0),
            seg_known(4095, 4095, 4095, 4095, HEADING_MINUS_HALF_PI, 1'b0),
            seg_known(10, 50, 30, 50, HEADING_MINUS_PI, 1'b0),
            seg_known(4095, 4095, 0, 4095, HEADING_MINUS_PI, 1'b0),
            seg_row(1, 1, 2, 3),
            seg_row(3, 2, 1, 1),
            seg_row(4095, 1, 0, 4095),
            seg_row(0, 4095, 4095, 1),
            seg_row(2048, 100, 2048, 3000),
            reg_row(glh_pkg::REG_CAM_H, 0),
            seg_known(10, 20, 30, 40, 0, 1'b1),
            reg_row(glh_pkg::REG_CAM_H, 65535),
            // zero focal length flattens every slope
            reg_row(glh_pkg::REG_FOCAL, 0),
            seg_known(10, 20, 30, 40, HEADING_MINUS_PI, 1'b0),
            reg_row(glh_pkg::REG_FOCAL, 65535),
            seg_row(1, 4095, 4095, 1),
            reg_row(glh_pkg::REG_ROI_X, -OFFS_MAX),
            reg_row(glh_pkg::REG_ROI_Y, OFFS_MAX),
            seg_known(0, 4095, 4095, 0, 0, 1'b1),
            seg_row(4095, 0, 0, 4094),
            reg_row(glh_pkg::REG_ROI_Y, -OFFS_MAX),
            seg_row(0, 0, 4095, 4095),
            seg_row(4095, 4095, 0, 0)
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_REGISTER)
            begin
                wait_drained();
                write_reg(directed_plan[i].index, int'(directed_plan[i].value));
            end
            else
                drive_segment(directed_plan[i].sx, directed_plan[i].sy,
                              directed_plan[i].ex, directed_plan[i].ey,
                              directed_plan[i].known, directed_plan[i].heading);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    rx = 0;
                    ry = 0;
                    ch = 1;
                    fl = 1024;
                end
                1:
                begin
                    rx = -OFFS_MAX;
                    ry = -OFFS_MAX;
                    ch = 65535;
                    fl = 65535;
                end
                2:
                begin
                    rx = OFFS_MAX;
                    ry = OFFS_MAX;
                    ch = 1;
                    fl = 1;
                end
                3:
                begin
                    // zero height, every result degenerate
                    rx = pick_offset();
                    ry = pick_offset();
                    ch = 0;
                    fl = $urandom_range(1, 65535);
                end
                default:
                begin
                    rx = pick_offset();
                    ry = ($urandom_range(0, 1)) ? int'($urandom_range(0, OFFS_MAX)) : pick_offset();
                    ch = ($urandom_range(0, 4) == 0) ? 65535 : int'($urandom_range(1, 65535));
                    case ($urandom_range(0, 9))
                        0:       fl = 0;
                        1:       fl = 1;
                        2:       fl = 65535;
                        default: fl = $urandom_range(1, 65535);
                    endcase
                end
            endcase

            // registers change only with the pipeline empty
            wait_drained();
            write_reg(glh_pkg::REG_ROI_X, rx);
            write_reg(glh_pkg::REG_ROI_Y, ry);
            write_reg(glh_pkg::REG_CAM_H, ch);
            write_reg(glh_pkg::REG_FOCAL, fl);
            settings_used++;

            if (phase == PHASES - 1 || phase % 3 == 0)
                gap_every = 0;
            else
                gap_every = (phase % 3 == 1) ? 3 : 10;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (gap_every != 0 && $urandom_range(1, gap_every) == 1)
                    idle($urandom_range(1, 13));
                pick_segment(sx, sy, ex, ey);
                drive_segment(sx, sy, ex, ey, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (LATENCY + 8) @(posedge clk);

        $display("%0d segments over %0d register settings plus directed writes",
                 segments_sent, settings_used);
        $display("results: %0d degenerate, %0d at -pi/2, %0d at -pi",
                 degen_seen, sideways_seen, backward_seen);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
